FILE: rtl/core/sorted_list_insert_delete_defines.svh
`ifndef SORTED_LIST_INSERT_DELETE_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_DEFINES_SVH

// same-cycle check, sampled on clk, idle during reset
`define SLI_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted list check failed");

// next-cycle check, sampled on clk, idle during reset
`define SLI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted list check failed");

`endif

FILE: rtl/core/sli_pkg.sv
`timescale 1ns / 1ps
package sli_pkg;

	localparam int KEY_PORT_W = 32;
	localparam int STATUS_W   = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DELETED   = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_UNDERFLOW = 3'd3,
		ST_FULL      = 3'd4
	} sli_status_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} sli_op_t;

	// broadcast to every cell for the cycle of an accepted request
	typedef struct packed {
		logic ins;
		logic del;
	} sli_ctrl_t;

endpackage

FILE: rtl/core/sli_cell.sv
`timescale 1ns / 1ps
module sli_cell #(
	parameter int KEY_WIDTH = 32
) (
	input  logic                        clk,
	input  sli_pkg::sli_ctrl_t          ctrl,
	input  logic signed [KEY_WIDTH-1:0] key,
	input  logic                        occ,
	input  logic                        prev_lt,
	input  logic signed [KEY_WIDTH-1:0] prev_key,
	input  logic signed [KEY_WIDTH-1:0] next_key,
	output logic                        lt,
	output logic                        eq,
	output logic signed [KEY_WIDTH-1:0] key_q
);
	import sli_pkg::*;

	assign lt = occ && (key_q < key);
	assign eq = occ && (key_q == key);

	// cells at or above the split point move: right on insert, left on delete
	always_ff @(posedge clk) begin
		if (ctrl.ins && !lt) begin
			key_q <= prev_lt ? key : prev_key;
		end else if (ctrl.del && !lt) begin
			key_q <= next_key;
		end
	end

endmodule

FILE: rtl/core/sorted_list_insert_delete.sv
// sorted list of signed keys, ascending, duplicates kept, up to CAPACITY entries
// request channel: req_valid / req_stall carry op (0 insert, 1 delete) and key
// response channel: rsp_valid / rsp_stall carry status, entry_count, is_empty
// every request gives exactly one response, in request order
// each entry sits in its own cell; all cells compare against the key in parallel
// and shift toward a neighbor in the same cycle
// latency: the response is valid on the cycle after the request is taken
// throughput: one request per cycle, limited only by the response register
// a request is taken while the response register is empty or being drained;
// while the receiver stalls a held response, req_stall is high and the
// response holds
// reset empties the list and drops any pending response; no clearing pass
// insert on a full list reports full and leaves the list as it was;
// delete on an empty list reports underflow, a missing key reports not found
`timescale 1ns / 1ps
`include "sorted_list_insert_delete_defines.svh"
module sorted_list_insert_delete #(
	parameter int CAPACITY  = 16,
	parameter int KEY_WIDTH = 32,
	localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic                              op,
	input  logic signed [sli_pkg::KEY_PORT_W-1:0] key,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [sli_pkg::STATUS_W-1:0]      status,
	output logic [CNT_W-1:0]                  entry_count,
	output logic                              is_empty
);
	import sli_pkg::*;

	logic signed [KEY_WIDTH-1:0] k_ext;
	logic [CNT_W-1:0]            count_q;
	logic                        rsp_valid_q;
	sli_status_t                 status_q;
	logic [CNT_W-1:0]            rsp_count_q;
	logic                        empty_q;

	logic                        accept;
	logic                        full;
	logic                        found;
	sli_ctrl_t                   ctrl;
	sli_status_t                 status_nxt;
	logic [CNT_W-1:0]            count_nxt;

	logic [CAPACITY-1:0]                       lt;
	logic [CAPACITY-1:0]                       eq;
	logic [CAPACITY-1:0]                       occ;
	logic signed [KEY_WIDTH-1:0]               cell_key [CAPACITY];

	if (KEY_WIDTH <= KEY_PORT_W) begin : g_key_narrow
		assign k_ext = key[KEY_WIDTH-1:0];
	end else begin : g_key_wide
		assign k_ext = {{(KEY_WIDTH - KEY_PORT_W){key[KEY_PORT_W-1]}}, key};
	end

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign found     = |eq;

	always_comb begin
		ctrl       = '0;
		status_nxt = ST_INSERTED;
		count_nxt  = count_q;
		if (op == OP_INSERT) begin
			if (full) begin
				status_nxt = ST_FULL;
			end else begin
				ctrl.ins   = accept;
				count_nxt  = count_q + CNT_W'(1);
			end
		end else begin
			if (count_q == '0) begin
				status_nxt = ST_UNDERFLOW;
			end else if (found) begin
				status_nxt = ST_DELETED;
				ctrl.del   = accept;
				count_nxt  = count_q - CNT_W'(1);
			end else begin
				status_nxt = ST_NOT_FOUND;
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                        prev_lt;
		logic signed [KEY_WIDTH-1:0] prev_key;
		logic signed [KEY_WIDTH-1:0] next_key;

		assign occ[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign prev_lt  = 1'b1;
			assign prev_key = k_ext;
		end else begin : g_mid
			assign prev_lt  = lt[i-1];
			assign prev_key = cell_key[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_key = cell_key[i];
		end else begin : g_inner
			assign next_key = cell_key[i+1];
		end

		sli_cell #(
			.KEY_WIDTH(KEY_WIDTH)
		) u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.key     (k_ext),
			.occ     (occ[i]),
			.prev_lt (prev_lt),
			.prev_key(prev_key),
			.next_key(next_key),
			.lt      (lt[i]),
			.eq      (eq[i]),
			.key_q   (cell_key[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_nxt;
			rsp_count_q <= count_nxt;
			empty_q     <= (count_nxt == '0);
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign entry_count = rsp_count_q;
	assign is_empty    = empty_q;

	`SLI_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY))
	`SLI_ASSERT_NEXT(a_insert_grows, accept && op == OP_INSERT && !full,
		count_q == $past(count_q) + CNT_W'(1) && status_q == ST_INSERTED)
	`SLI_ASSERT_NEXT(a_underflow, accept && op == OP_DELETE && count_q == '0,
		rsp_valid && status_q == ST_UNDERFLOW && count_q == '0)
	`SLI_ASSERT_NOW(a_empty_flag, rsp_valid, is_empty == (entry_count == '0))

endmodule
